@@ rtl/core/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stream pattern redactor.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

    // Longest pattern the window can hold.
    localparam int MAX_PATTERN = 8;
    // The pattern register carries eight characters.
    localparam int PAT_CHARS   = 8;
    localparam int LEN_CAP     = (MAX_PATTERN < PAT_CHARS) ? MAX_PATTERN : PAT_CHARS;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REDACT_CHAR    = CFG_IDX_W'(2);

    localparam logic [7:0] REDACT_RESET = 8'd48;

    // Group queue between front and back
    localparam int GQ_DEPTH = 4;
    localparam int GQ_PTR_W = $clog2(GQ_DEPTH);
    localparam int GQ_CNT_W = $clog2(GQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // All result bytes caused by one input item, already substituted.
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] bytes;
        logic [CNT_W-1:0]            cnt;
        logic                        last;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

`default_nettype wire

@@ rtl/core/spr_front.sv @@
// ----------------------------------------------------------------------------
// spr_front
// Holds the configuration and the byte window, runs the parallel pattern
// compare and pushes each item's outgoing bytes as one group.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_front import spr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  t_in_item              i_item,
    input  t_fifo_stat            i_q_stat,
    output logic                  o_full,
    output logic                  o_grp_push,
    output t_group                o_grp
);

    logic [63:0]      r_pat;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_redact;

    logic [7:0]       r_win  [MAX_PATTERN];
    logic             r_mark [MAX_PATTERN];
    logic [CNT_W-1:0] r_fill;

    logic [7:0]       n_win  [MAX_PATTERN];
    logic             n_mark [MAX_PATTERN];
    logic [CNT_W-1:0] n_fill;

    logic [7:0]       w_buf [MAX_PATTERN];
    logic             w_mk  [MAX_PATTERN];
    logic [CNT_W:0]   w_src [MAX_PATTERN];
    logic [CNT_W-1:0] w_len;
    logic [CNT_W-1:0] w_tot;
    logic [CNT_W-1:0] w_lo;
    logic [CNT_W-1:0] w_keep;
    logic [CNT_W-1:0] w_emit;
    logic             w_test;
    logic             w_hit;
    logic             w_accept;

    assign w_accept = i_push && !i_q_stat.full;
    assign o_full   = i_q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat    <= '0;
            r_len    <= '0;
            r_redact <= REDACT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_BYTES:  r_pat    <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_REDACT_CHAR:    r_redact <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_len = (r_len > LEN_W'(LEN_CAP)) ? CNT_W'(LEN_CAP) : CNT_W'(r_len);
        w_tot = r_fill + CNT_W'(1);
        w_test = (w_len != '0) && (w_tot >= w_len);
        w_lo = w_tot - w_len;

        // Held bytes followed by the new byte.
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) < r_fill) begin
                w_buf[i] = r_win[i];
            end else if (CNT_W'(i) == r_fill) begin
                w_buf[i] = i_item.text_byte;
            end else begin
                w_buf[i] = '0;
            end
        end

        w_hit = w_test;
        for (int j = 0; j < LEN_CAP; j++) begin
            if (CNT_W'(j) < w_len &&
                w_buf[IDX_W'(w_lo + CNT_W'(j))] != r_pat[8*j +: 8]) begin
                w_hit = 1'b0;
            end
        end

        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_mk[i] = ((CNT_W'(i) < r_fill) && r_mark[i]) ||
                      (w_hit && CNT_W'(i) >= w_lo && CNT_W'(i) < w_tot);
        end

        w_keep = (w_len == '0) ? '0 : w_len - CNT_W'(1);
        if (i_item.end_of_text) begin
            w_emit = w_tot;
        end else begin
            w_emit = (w_tot > w_keep) ? w_tot - w_keep : '0;
        end

        for (int i = 0; i < MAX_PATTERN; i++) begin
            o_grp.bytes[i] = w_mk[i] ? r_redact : w_buf[i];
        end
        o_grp.cnt  = w_emit;
        o_grp.last = i_item.end_of_text;

        // Bytes that stay slide down to the front of the window.
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_src[i] = {1'b0, w_emit} + (CNT_W + 1)'(i);
            if (w_src[i] < (CNT_W + 1)'(MAX_PATTERN)) begin
                n_win[i]  = w_buf[w_src[i][IDX_W-1:0]];
                n_mark[i] = w_mk[w_src[i][IDX_W-1:0]];
            end else begin
                n_win[i]  = '0;
                n_mark[i] = 1'b0;
            end
        end
        n_fill = i_item.end_of_text ? '0 : w_tot - w_emit;
    end

    assign o_grp_push = w_accept && (w_emit != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_mark[i] <= 1'b0;
            end
        end else if (w_accept) begin
            r_fill <= n_fill;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_mark[i] <= n_mark[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/spr_gfifo.sv @@
// ----------------------------------------------------------------------------
// spr_gfifo
// Short queue of byte groups between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_gfifo import spr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_group     i_grp,
    input  logic       i_pop,
    output t_group     o_head,
    output t_fifo_stat o_stat
);

    t_group              r_mem [GQ_DEPTH];
    logic [GQ_PTR_W-1:0] r_wr_ptr;
    logic [GQ_PTR_W-1:0] r_rd_ptr;
    logic [GQ_CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_stat.full  = (r_count == GQ_CNT_W'(GQ_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + GQ_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + GQ_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + GQ_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - GQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/spr_back.sv @@
// ----------------------------------------------------------------------------
// spr_back
// Walks the head group byte by byte into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_back import spr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_group     i_head,
    input  t_fifo_stat i_q_stat,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output t_out_item  o_item
);

    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out;

    logic w_load;
    logic w_last_byte;

    assign w_last_byte = (CNT_W'(r_idx) + CNT_W'(1) == i_head.cnt);
    assign w_load      = !i_q_stat.empty && (!r_out_valid || i_pop);
    assign o_q_pop     = w_load && w_last_byte;
    assign o_empty     = !r_out_valid;
    assign o_item      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_idx       <= w_last_byte ? '0 : r_idx + IDX_W'(1);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.out_byte <= i_head.bytes[r_idx];
            r_out.out_last <= i_head.last && w_last_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/stream_pattern_redactor.sv @@
// ----------------------------------------------------------------------------
// stream_pattern_redactor
// Replaces every text byte covered by a match of the configured pattern
// with the redact character; bytes leave in order, held back by the window.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  input     in         push / full        i_in_item  (text_byte, end_of_text)
//  result    out        pop / empty        o_out_item (out_byte, out_last)
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
//  The front takes one byte per cycle while the group queue has room; the
//  compare over the whole window is done in that same cycle.
//  The back sends one result byte per cycle while pop keeps the output
//  register free, so a byte that pushes one result out sustains one item
//  per cycle; an end-of-text item yields up to MAX_PATTERN bytes and holds
//  the front back only once the queue fills. A result enters the group
//  queue at the edge accepting its item, then passes to the output register.
//  Reset is synchronous, empties window, queue and output, restores config.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_pattern_redactor import spr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_in_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_out_item
);

    logic       w_grp_push;
    t_group     w_grp;
    t_group     w_head;
    t_fifo_stat w_q_stat;
    logic       w_q_pop;

    spr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_in_item),
        .i_q_stat    (w_q_stat),
        .o_full      (full),
        .o_grp_push  (w_grp_push),
        .o_grp       (w_grp)
    );

    spr_gfifo u_gfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_grp_push),
        .i_grp   (w_grp),
        .i_pop   (w_q_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    spr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_q_pop  (w_q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_out_item)
    );

endmodule

`default_nettype wire

@@ rtl/core/spr_checker.sv @@
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks of the stream pattern redactor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_checker import spr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out_item
);

    // Out of reset nothing is waiting and input is open.
    a_reset_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("queue not clear after reset");

    // A full group queue implies the output register already holds an item.
    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input stalled while no result is offered");

    // A waiting result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed before pop");

    // An offered result carries only known bits.
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown(o_out_item))
        else $error("offered result has unknown bits");

endmodule

bind stream_pattern_redactor spr_checker u_spr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);

`default_nettype wire
